// ===== src/aescbc_pkg.sv =====
// Shared types, constants and cipher round functions for the AES-CBC block.
`default_nettype none
package aescbc_pkg;

   localparam int BLOCK_W = 128;
   localparam int HALF_W = 64;
   localparam int WORD_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int KEY_WORDS = 4;       // 64-bit key registers
   localparam int KEY_ROWS = 15;       // 128-bit round keys, up to 14 rounds + 1
   localparam int ROW_W = 4;
   localparam int WIDX_W = 6;          // schedule word index, up to 59
   localparam int RND_W = 4;
   localparam int WIN_DEPTH = 8;       // longest key (Nk = 8)

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY_WORD_0 = 3'd0,
      REG_KEY_WORD_1 = 3'd1,
      REG_KEY_WORD_2 = 3'd2,
      REG_KEY_WORD_3 = 3'd3,
      REG_KEY_LENGTH = 3'd4,
      REG_IV_HIGH    = 3'd5,
      REG_IV_LOW     = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      KLEN_128 = 2'd0,
      KLEN_192 = 2'd1,
      KLEN_256 = 2'd2,
      KLEN_RSVD = 2'd3
   } klen_type;

   localparam logic [RND_W-1:0] ROUNDS_128 = 4'd10;
   localparam logic [RND_W-1:0] ROUNDS_192 = 4'd12;
   localparam logic [RND_W-1:0] ROUNDS_256 = 4'd14;
   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY = 8'h1b;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_PRIME,
      ST_ADDKEY,
      ST_ROUND,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic exp_start;
      logic exp_step;
      logic prime;
      logic addkey;
      logic round;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic keys_ready;
      logic exp_last;
      logic round_last;
      logic out_free;
   } ctrl_status_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Inverse table, built at elaboration from the forward one
   function automatic sbox_table_type invert_table(input sbox_table_type fwd);
      sbox_table_type inv;
      for (int i = 0; i < 256; i++) begin
         inv[fwd[i]] = 8'(i);
      end
      return inv;
   endfunction

   localparam sbox_table_type SBOX_REV = invert_table(SBOX);

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [WORD_W-1:0] subst_word(input logic [WORD_W-1:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [WORD_W-1:0] mix_col(input logic [WORD_W-1:0] w);
      logic [7:0] a0, a1, a2, a3;
      a0 = w[31:24];
      a1 = w[23:16];
      a2 = w[15:8];
      a3 = w[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   function automatic logic [WORD_W-1:0] inv_mix_col(input logic [WORD_W-1:0] w);
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      for (int k = 0; k < 4; k++) begin
         a[k] = w[31-8*k -: 8];
         m2[k] = xtime(a[k]);
         m4[k] = xtime(m2[k]);
         m8[k] = xtime(m4[k]);
         m9[k] = m8[k] ^ a[k];
         m11[k] = m8[k] ^ m2[k] ^ a[k];
         m13[k] = m8[k] ^ m4[k] ^ a[k];
         m14[k] = m8[k] ^ m4[k] ^ m2[k];
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   // Byte k of the block sits at bits 127-8k downto 120-8k
   function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [BLOCK_W-1:0] rk,
                                                    input logic last);
      logic [7:0] a [16];
      logic [BLOCK_W-1:0] v;
      for (int k = 0; k < 16; k++) begin
         a[k] = SBOX[s[127-8*k -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v[127-8*(4*c+r) -: 8] = a[4*((c+r)&3)+r];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            v[127-32*c -: 32] = mix_col(v[127-32*c -: 32]);
         end
      end
      return v ^ rk;
   endfunction

   function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [BLOCK_W-1:0] rk,
                                                    input logic last);
      logic [7:0] a [16];
      logic [BLOCK_W-1:0] v;
      for (int k = 0; k < 16; k++) begin
         a[k] = s[127-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v[127-8*(4*((c+r)&3)+r) -: 8] = SBOX_REV[a[4*c+r]];
         end
      end
      v = v ^ rk;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            v[127-32*c -: 32] = inv_mix_col(v[127-32*c -: 32]);
         end
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== src/aescbc_if.sv =====
// Channel interfaces: block requests, block responses and register writes.
`default_nettype none
interface aescbc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic        first_block;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source (output valid, mode, first_block, data_high, data_low, input ready);
   modport sink (input valid, mode, first_block, data_high, data_low, output ready);
endinterface

interface aescbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aescbc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/aes_cbc_cipher.sv =====
// Top level: AES-128/192/256 CBC block cipher, one 128-bit block per transaction.
// The single shared round unit runs one round per cycle (Nr = 10, 12 or 14 rounds); the next
// block is taken only after the last result has been moved into the output register.
// A block goes through the prime, add-key and round states to the output state; the key
// schedule is first rebuilt, one word per cycle, after a key or key length write.
// Reset (synchronous): registers, IV and chain value to zero, key schedule marked stale.
`default_nettype none
module aes_cbc_cipher (
   input  wire logic  clock,
   input  wire logic  reset,
   aescbc_req_if.sink   req_ch,
   aescbc_rsp_if.source rsp_ch,
   aescbc_csr_if.sink   csr_ch
);

   aescbc_pkg::ctrl_cmd_type    cmd;
   aescbc_pkg::ctrl_status_type status;

   assign csr_ch.ready = 1'b1;

   aescbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   aescbc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .req_mode        (req_ch.mode),
      .req_first_block (req_ch.first_block),
      .req_data_high   (req_ch.data_high),
      .req_data_low    (req_ch.data_low),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_result_high (rsp_ch.result_high),
      .rsp_result_low  (rsp_ch.result_low),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
`default_nettype wire

// ===== src/aescbc_ctrl.sv =====
// Sequencer: key expansion, round iteration and result hand-off.
`default_nettype none
module aescbc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire aescbc_pkg::ctrl_status_type status,
   output aescbc_pkg::ctrl_cmd_type        cmd
);

   aescbc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aescbc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aescbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.keys_ready ? aescbc_pkg::ST_PRIME : aescbc_pkg::ST_EXPAND;
            end
         end
         aescbc_pkg::ST_EXPAND: begin
            if (status.exp_last) state_in = aescbc_pkg::ST_PRIME;
         end
         aescbc_pkg::ST_PRIME:  state_in = aescbc_pkg::ST_ADDKEY;
         aescbc_pkg::ST_ADDKEY: state_in = aescbc_pkg::ST_ROUND;
         aescbc_pkg::ST_ROUND: begin
            if (status.round_last) state_in = aescbc_pkg::ST_OUT;
         end
         aescbc_pkg::ST_OUT: begin
            if (status.out_free) state_in = aescbc_pkg::ST_IDLE;
         end
         default: state_in = aescbc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         aescbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
            cmd.exp_start = req_valid && !status.keys_ready;
         end
         aescbc_pkg::ST_EXPAND: cmd.exp_step = 1'b1;
         aescbc_pkg::ST_PRIME:  cmd.prime = 1'b1;
         aescbc_pkg::ST_ADDKEY: cmd.addkey = 1'b1;
         aescbc_pkg::ST_ROUND:  cmd.round = 1'b1;
         aescbc_pkg::ST_OUT:    cmd.emit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/aescbc_dp.sv =====
// Datapath: registers, key schedule store, shared round unit, CBC chain, output stage.
`default_nettype none
module aescbc_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [63:0]                csr_data,
   input  wire logic                       req_mode,
   input  wire logic                       req_first_block,
   input  wire logic [63:0]                req_data_high,
   input  wire logic [63:0]                req_data_low,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [63:0]                     rsp_result_high,
   output logic [63:0]                     rsp_result_low,
   input  wire aescbc_pkg::ctrl_cmd_type   cmd,
   output aescbc_pkg::ctrl_status_type     status
);

   localparam int BW = aescbc_pkg::BLOCK_W;
   localparam int WW = aescbc_pkg::WORD_W;

   logic [63:0]     key_ff [aescbc_pkg::KEY_WORDS];
   logic [1:0]      klen_ff;
   logic [63:0]     iv_hi_ff, iv_lo_ff;
   logic            keys_ready_ff;

   logic [aescbc_pkg::RND_W-1:0]  nr, nk;
   logic [aescbc_pkg::WIDX_W-1:0] total;

   logic [aescbc_pkg::WIDX_W-1:0] widx_ff;
   logic [2:0]                    wmod_ff;
   logic [7:0]                    rc_ff;
   logic [WW-1:0]                 win_ff [aescbc_pkg::WIN_DEPTH];
   logic [WW-1:0]                 word_in, tmp, key_half;

   logic [WW-1:0] rk_mem [4][aescbc_pkg::KEY_ROWS];
   logic [BW-1:0] rk_rd_ff;
   logic [aescbc_pkg::ROW_W-1:0] row_ff;
   logic [aescbc_pkg::RND_W-1:0] rnd_ff;

   logic          dec_ff;
   logic [BW-1:0] data_ff, chain_ff, state_ff, result;
   logic          rsp_valid_ff;
   logic [BW-1:0] rsp_data_ff;
   logic          round_last;

   always_comb begin
      unique case (klen_ff)
         aescbc_pkg::KLEN_128: nr = aescbc_pkg::ROUNDS_128;
         aescbc_pkg::KLEN_192: nr = aescbc_pkg::ROUNDS_192;
         default:              nr = aescbc_pkg::ROUNDS_256;
      endcase
      nk = nr - 4'd6;
      total = {nr[3:0], 2'b00} + 6'd4;
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < aescbc_pkg::KEY_WORDS; k++) key_ff[k] <= '0;
         klen_ff <= aescbc_pkg::KLEN_128;
         iv_hi_ff <= '0;
         iv_lo_ff <= '0;
         keys_ready_ff <= 1'b0;
      end else begin
         if (cmd.exp_step && status.exp_last) keys_ready_ff <= 1'b1;
         if (csr_valid) begin
            unique case (aescbc_pkg::csr_reg_type'(csr_index)) inside
               aescbc_pkg::REG_KEY_WORD_0,
               aescbc_pkg::REG_KEY_WORD_1,
               aescbc_pkg::REG_KEY_WORD_2,
               aescbc_pkg::REG_KEY_WORD_3: begin
                  key_ff[csr_index[1:0]] <= csr_data;
                  keys_ready_ff <= 1'b0;
               end
               aescbc_pkg::REG_KEY_LENGTH: begin
                  klen_ff <= (csr_data[1:0] == aescbc_pkg::KLEN_RSVD) ?
                             aescbc_pkg::KLEN_256 : csr_data[1:0];
                  keys_ready_ff <= 1'b0;
               end
               aescbc_pkg::REG_IV_HIGH: iv_hi_ff <= csr_data;
               aescbc_pkg::REG_IV_LOW:  iv_lo_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Key schedule: one word per cycle, last Nk words kept in a shift line
   always_comb begin
      key_half = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0] : key_ff[widx_ff[2:1]][63:32];
      tmp = win_ff[0];
      if (wmod_ff == 3'd0) begin
         tmp = aescbc_pkg::subst_word({tmp[23:0], tmp[31:24]}) ^ {rc_ff, 24'd0};
      end else if (nk == 4'd8 && wmod_ff == 3'd4) begin
         tmp = aescbc_pkg::subst_word(tmp);
      end
      if (widx_ff < 6'(nk)) begin
         word_in = key_half;
      end else begin
         word_in = win_ff[3'(nk - 4'd1)] ^ tmp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_start) begin
         widx_ff <= '0;
         wmod_ff <= '0;
         rc_ff <= aescbc_pkg::RCON_INIT;
      end else if (cmd.exp_step) begin
         widx_ff <= widx_ff + 6'd1;
         wmod_ff <= (wmod_ff == 3'(nk - 4'd1)) ? 3'd0 : wmod_ff + 3'd1;
         if (wmod_ff == 3'd0 && widx_ff >= 6'(nk)) rc_ff <= aescbc_pkg::xtime(rc_ff);
         win_ff[0] <= word_in;
         for (int k = 1; k < aescbc_pkg::WIN_DEPTH; k++) win_ff[k] <= win_ff[k-1];
         rk_mem[widx_ff[1:0]][widx_ff[5:2]] <= word_in;
      end
   end

   // Round-key store read, one 128-bit row per cycle
   always_ff @(posedge clock) begin
      rk_rd_ff <= {rk_mem[0][row_ff], rk_mem[1][row_ff], rk_mem[2][row_ff], rk_mem[3][row_ff]};
   end

   assign round_last = (rnd_ff == nr);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= req_mode ? nr : '0;
      end else if (cmd.prime || cmd.addkey || (cmd.round && !round_last)) begin
         row_ff <= dec_ff ? row_ff - 4'd1 : row_ff + 4'd1;
      end
      if (cmd.addkey) begin
         rnd_ff <= 4'd1;
      end else if (cmd.round) begin
         rnd_ff <= rnd_ff + 4'd1;
      end
   end

   // Block state and chain
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dec_ff <= req_mode;
         data_ff <= {req_data_high, req_data_low};
      end
      if (cmd.addkey) begin
         state_ff <= (dec_ff ? data_ff : data_ff ^ chain_ff) ^ rk_rd_ff;
      end else if (cmd.round) begin
         state_ff <= dec_ff ? aescbc_pkg::dec_round(state_ff, rk_rd_ff, round_last)
                            : aescbc_pkg::enc_round(state_ff, rk_rd_ff, round_last);
      end
   end

   assign result = dec_ff ? state_ff ^ chain_ff : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (cmd.load && req_first_block) begin
         chain_ff <= {iv_hi_ff, iv_lo_ff};
      end else if (cmd.emit) begin
         chain_ff <= dec_ff ? data_ff : state_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_high = rsp_data_ff[127:64];
   assign rsp_result_low = rsp_data_ff[63:0];

   assign status.keys_ready = keys_ready_ff;
   assign status.exp_last = (widx_ff == total - 6'd1);
   assign status.round_last = round_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ===== tb/aescbc_checker.sv =====
// Watches the AES-CBC channels, predicts each result block and compares it.
`timescale 1ns / 1ps
`default_nettype none
module aescbc_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire logic         req_mode,
   input  wire logic         req_first_block,
   input  wire logic [63:0]  req_data_high,
   input  wire logic [63:0]  req_data_low,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire logic [63:0]  rsp_result_high,
   input  wire logic [63:0]  rsp_result_low,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data,
   output int                error_count,
   output int                pending_blocks
);

   logic [63:0]  key_regs [aescbc_pkg::KEY_WORDS];
   aescbc_pkg::klen_type key_len;
   logic [63:0]  iv_hi, iv_lo;
   logic [31:0]  sched [60];
   logic         sched_valid;
   logic [127:0] chain;
   logic [7:0]   inv_box [256];
   logic [127:0] expected_blocks [$];

   initial begin
      for (int i = 0; i < 256; i++) begin
         inv_box[aescbc_pkg::SBOX[i]] = 8'(i);
      end
   end

   assign pending_blocks = expected_blocks.size();

   function automatic int rounds_for(aescbc_pkg::klen_type k);
      return k == aescbc_pkg::KLEN_128 ? 10 : (k == aescbc_pkg::KLEN_192 ? 12 : 14);
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, int b);
      logic [7:0] r;
      r = 8'h00;
      while (b != 0) begin
         if (b[0]) r = r ^ a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [7:0] byte_at(logic [127:0] s, int k);
      return s[127-8*k -: 8];
   endfunction

   function automatic logic [127:0] sub_shift(logic [127:0] s, bit inverse);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inverse)
               t[127-8*(4*((c+r)&3)+r) -: 8] = inv_box[byte_at(s, 4*c+r)];
            else
               t[127-8*(4*c+r) -: 8] = aescbc_pkg::SBOX[byte_at(s, 4*((c+r)&3)+r)];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_state(logic [127:0] s, bit inverse);
      int m [4];
      logic [127:0] t;
      logic [7:0] a [4];
      if (inverse) m = '{14, 11, 13, 9};
      else m = '{2, 3, 1, 1};
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) a[i] = byte_at(s, 4*c+i);
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = gmul(a[0], m[(4-r)&3]) ^ gmul(a[1], m[(5-r)&3]) ^
                                    gmul(a[2], m[(6-r)&3]) ^ gmul(a[3], m[(7-r)&3]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] round_key(int r);
      return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
   endfunction

   task automatic build_schedule();
      int nr, nk;
      logic [31:0] t;
      logic [7:0] rc;
      nr = rounds_for(key_len);
      nk = nr - 6;
      rc = 8'h01;
      for (int i = 0; i < nk; i++) begin
         sched[i] = i[0] ? key_regs[(i>>1)&3][31:0] : key_regs[(i>>1)&3][63:32];
      end
      for (int i = nk; i < 4*(nr+1); i++) begin
         t = sched[i-1];
         if (i % nk == 0) begin
            t = {t[23:0], t[31:24]};
            t = {aescbc_pkg::SBOX[t[31:24]], aescbc_pkg::SBOX[t[23:16]],
                 aescbc_pkg::SBOX[t[15:8]], aescbc_pkg::SBOX[t[7:0]]} ^ {rc, 24'h0};
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end else if (nk == 8 && i % nk == 4) begin
            t = {aescbc_pkg::SBOX[t[31:24]], aescbc_pkg::SBOX[t[23:16]],
                 aescbc_pkg::SBOX[t[15:8]], aescbc_pkg::SBOX[t[7:0]]};
         end
         sched[i] = sched[i-nk] ^ t;
      end
      sched_valid = 1'b1;
   endtask

   function automatic logic [127:0] encipher(logic [127:0] s);
      int nr;
      nr = rounds_for(key_len);
      s = s ^ round_key(0);
      for (int r = 1; r <= nr; r++) begin
         s = sub_shift(s, 1'b0);
         if (r < nr) s = mix_state(s, 1'b0);
         s = s ^ round_key(r);
      end
      return s;
   endfunction

   function automatic logic [127:0] decipher(logic [127:0] s);
      int nr;
      nr = rounds_for(key_len);
      s = s ^ round_key(nr);
      for (int r = nr; r > 0; r--) begin
         s = sub_shift(s, 1'b1);
         s = s ^ round_key(r - 1);
         if (r > 1) s = mix_state(s, 1'b1);
      end
      return s;
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      logic [127:0] blk, res, want;
      if (reset) begin
         foreach (key_regs[i]) key_regs[i] = '0;
         key_len = aescbc_pkg::KLEN_128;
         iv_hi = '0;
         iv_lo = '0;
         sched_valid = 1'b0;
         chain = '0;
         expected_blocks.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index) inside
               aescbc_pkg::REG_KEY_WORD_0, aescbc_pkg::REG_KEY_WORD_1,
               aescbc_pkg::REG_KEY_WORD_2, aescbc_pkg::REG_KEY_WORD_3: begin
                  key_regs[csr_index[1:0]] = csr_data;
                  sched_valid = 1'b0;
               end
               aescbc_pkg::REG_KEY_LENGTH: begin
                  key_len = (csr_data[1:0] == aescbc_pkg::KLEN_RSVD) ? aescbc_pkg::KLEN_256 :
                            aescbc_pkg::klen_type'(csr_data[1:0]);
                  sched_valid = 1'b0;
               end
               aescbc_pkg::REG_IV_HIGH: iv_hi = csr_data;
               aescbc_pkg::REG_IV_LOW: iv_lo = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (!sched_valid) build_schedule();
            if (req_first_block) chain = {iv_hi, iv_lo};
            blk = {req_data_high, req_data_low};
            if (req_mode) begin
               res = decipher(blk) ^ chain;
               chain = blk;
            end else begin
               res = encipher(blk ^ chain);
               chain = res;
            end
            expected_blocks.push_back(res);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("result with no block outstanding");
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_result_high !== want[127:64])
                  report_mismatch($sformatf("result_high %h, want %h",
                                            rsp_result_high, want[127:64]));
               if (rsp_result_low !== want[63:0])
                  report_mismatch($sformatf("result_low %h, want %h",
                                            rsp_result_low, want[63:0]));
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/aes_cbc_cipher_test.sv =====
// Testbench top: drives blocks and register writes into the AES-CBC cipher, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module aes_cbc_cipher_test;

   localparam logic [2:0] UNUSED_INDEX = 3'd7;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_BLOCKS = 1100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   error_count, pending_blocks, idle_cycles;
   int   stall_left = 0;

   aescbc_req_if req_ch ();
   aescbc_rsp_if rsp_ch ();
   aescbc_csr_if csr_ch ();

   aes_cbc_cipher dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
                       .csr_ch(csr_ch));

   aescbc_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_mode(req_ch.mode),
      .req_first_block(req_ch.first_block), .req_data_high(req_ch.data_high),
      .req_data_low(req_ch.data_low),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_result_high(rsp_ch.result_high), .rsp_result_low(rsp_ch.result_low),
      .csr_valid(csr_ch.valid), .csr_ready(csr_ch.ready), .csr_index(csr_ch.index),
      .csr_data(csr_ch.data),
      .error_count(error_count), .pending_blocks(pending_blocks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = 1'b0;
      req_ch.first_block = 1'b0;
      req_ch.data_high = '0;
      req_ch.data_low = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] pick64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic send_block(logic mode, logic first, logic [63:0] hi, logic [63:0] lo);
      sender_gap();
      req_ch.valid = 1'b1;
      req_ch.mode = mode;
      req_ch.first_block = first;
      req_ch.data_high = hi;
      req_ch.data_low = lo;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_blocks != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic load_settings(aescbc_pkg::klen_type klen, logic [63:0] fill);
      write_reg(aescbc_pkg::REG_KEY_WORD_0, fill === 'x ? pick64() : fill);
      write_reg(aescbc_pkg::REG_KEY_WORD_1, pick64());
      write_reg(aescbc_pkg::REG_KEY_WORD_2, pick64());
      write_reg(aescbc_pkg::REG_KEY_WORD_3, fill === 'x ? pick64() : fill);
      write_reg(aescbc_pkg::REG_KEY_LENGTH, {62'h0, klen});
      write_reg(aescbc_pkg::REG_IV_HIGH, pick64());
      write_reg(aescbc_pkg::REG_IV_LOW, pick64());
   endtask

   initial begin
      int sent, msg_len;
      logic dir;
      sent = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // zero key and zero chain straight out of reset, no message start
      send_block(1'b0, 1'b0, '0, '0);
      send_block(1'b1, 1'b0, '1, '1);
      drain();
      load_settings(aescbc_pkg::KLEN_128, '1);
      send_block(1'b0, 1'b1, '1, '0);
      send_block(1'b0, 1'b0, '0, '1);
      send_block(1'b1, 1'b0, pick64(), pick64());
      // IV rewrite mid-message only counts at the next message start
      drain();
      write_reg(aescbc_pkg::REG_IV_HIGH, '1);
      write_reg(aescbc_pkg::REG_IV_LOW, '0);
      send_block(1'b1, 1'b0, pick64(), pick64());
      send_block(1'b0, 1'b1, pick64(), pick64());
      drain();
      write_reg(UNUSED_INDEX, '1);
      send_block(1'b1, 1'b0, pick64(), pick64());
      drain();
      load_settings(aescbc_pkg::KLEN_192, '0);
      send_block(1'b0, 1'b1, pick64(), pick64());
      send_block(1'b1, 1'b1, pick64(), pick64());
      drain();
      load_settings(aescbc_pkg::KLEN_256, '1);
      send_block(1'b1, 1'b1, '0, '0);
      send_block(1'b0, 1'b0, '1, '1);
      drain();
      load_settings(aescbc_pkg::KLEN_RSVD, 'x);
      send_block(1'b0, 1'b1, pick64(), pick64());
      send_block(1'b1, 1'b0, pick64(), pick64());
      drain();

      while (sent < RANDOM_BLOCKS) begin
         if (sent % 120 == 0) begin
            drain();
            load_settings(aescbc_pkg::klen_type'($urandom_range(0, 3)), 'x);
         end
         if (sent > RANDOM_BLOCKS - 100) quiet = 1'b1;
         msg_len = $urandom_range(1, 8);
         dir = 1'($urandom_range(0, 1));
         for (int i = 0; i < msg_len; i++) begin
            send_block($urandom_range(0, 7) == 0 ? !dir : dir,
                       i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                       pick64(), pick64());
            sent++;
         end
      end

      while (pending_blocks != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
